// ===== src/ubs_pkg.sv =====
package ubs_pkg;

    localparam logic [7:0] QMARK           = 8'h3F;
    localparam int         UBS_QUEUE_DEPTH = 5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // One input byte's worth of output: up to four bytes, count stored minus one.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt_m1;
        logic            last;
    } t_burst;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        case (b) inside
            [8'h00:8'h7F]: len = 3'd1;
            [8'hC2:8'hDF]: len = 3'd2;
            [8'hE0:8'hEF]: len = 3'd3;
            [8'hF0:8'hF4]: len = 3'd4;
            default:       len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        ok = is_cont(b);
        if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
        if (lead == 8'hED && b > 8'h9F) ok = 1'b0;
        if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
        if (lead == 8'hF4 && b > 8'h8F) ok = 1'b0;
        return ok;
    endfunction

endpackage

// ===== src/ubs_front.sv =====
module ubs_front import ubs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_in_beat,
    input  logic     i_full,
    output logic     o_push,
    output t_burst   o_burst
);

    logic [7:0]      r_lead, n_lead;
    logic [2:0]      r_need, n_need;
    logic [1:0]      r_hc, n_hc;
    logic [1:0][7:0] r_c;

    logic [7:0]      b;
    logic            last;
    logic            accept;
    logic [2:0]      fr_len;
    logic            fr_emit;
    logic [7:0]      fr_byte;
    logic            ok;
    logic [2:0]      hc_ext;
    logic            open_fresh;
    logic            cont_we;
    logic [2:0]      n_out;
    logic [3:0][7:0] bytes;

    assign b      = i_in_beat.in_byte;
    assign last   = i_in_beat.in_last;
    assign accept = i_valid && !i_full;

    always_comb begin
        fr_len     = lead_length(b);
        fr_emit    = (fr_len == 3'd1) || (fr_len == 3'd0) || last;
        fr_byte    = (fr_len == 3'd1) ? b : QMARK;
        ok         = (r_hc == 2'd0) ? second_ok(r_lead, b) : is_cont(b);
        hc_ext     = {1'b0, r_hc};
        bytes      = {4{QMARK}};
        n_out      = 3'd0;
        n_lead     = r_lead;
        n_need     = r_need;
        n_hc       = r_hc;
        cont_we    = 1'b0;
        open_fresh = 1'b0;

        if (r_need == 3'd0) begin
            n_out      = {2'b00, fr_emit};
            bytes[0]   = fr_byte;
            open_fresh = !fr_emit;
        end else if (ok) begin
            if (hc_ext + 3'd2 >= r_need) begin
                // sequence complete: lead, held continuations, this byte
                bytes[0] = r_lead;
                bytes[1] = (r_hc == 2'd0) ? b : r_c[0];
                bytes[2] = (r_hc == 2'd1) ? b : r_c[1];
                bytes[3] = b;
                n_out    = hc_ext + 3'd2;
                n_need   = 3'd0;
                n_hc     = 2'd0;
            end else if (last) begin
                n_out  = hc_ext + 3'd2;
                n_need = 3'd0;
                n_hc   = 2'd0;
            end else begin
                cont_we = 1'b1;
                n_hc    = r_hc + 2'd1;
            end
        end else begin
            // broken sequence: lead and held bytes become '?', byte decoded afresh
            n_out               = hc_ext + 3'd1 + {2'b00, fr_emit};
            bytes[r_hc + 2'd1]  = fr_byte;
            n_need              = 3'd0;
            n_hc                = 2'd0;
            open_fresh          = !fr_emit;
        end

        if (open_fresh) begin
            n_lead = b;
            n_need = fr_len;
            n_hc   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 8'd0;
            r_need <= 3'd0;
            r_hc   <= 2'd0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_need <= n_need;
            r_hc   <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cont_we) begin
            r_c[r_hc[0]] <= b;
        end
    end

    assign o_push         = accept && (n_out != 3'd0);
    assign o_burst.bytes  = bytes;
    assign o_burst.cnt_m1 = 2'(n_out - 3'd1);
    assign o_burst.last   = last;

endmodule

// ===== src/ubs_queue.sv =====
module ubs_queue import ubs_pkg::*; #(
    parameter int DEPTH = UBS_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_burst i_burst,
    input  logic   i_pop,
    output t_burst o_head,
    output logic   o_head_valid,
    output logic   o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_burst          r_slots [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_burst;
        end
    end

    assign o_head       = r_slots[r_rd];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == CW'(DEPTH));

endmodule

// ===== src/ubs_back.sv =====
module ubs_back import ubs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_burst    i_head,
    input  logic      i_head_valid,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_beat o_out_beat,
    output logic      o_pop
);

    logic [1:0] r_idx, n_idx;
    logic       is_end;
    logic       beat_ok;

    assign is_end  = (r_idx == i_head.cnt_m1);
    assign beat_ok = i_head_valid && !i_stall;

    always_comb begin
        n_idx = r_idx;
        if (beat_ok) begin
            n_idx = is_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

    assign o_valid             = i_head_valid;
    assign o_out_beat.out_byte = i_head.bytes[r_idx];
    assign o_out_beat.out_last = i_head.last && is_end;
    assign o_pop               = beat_ok && is_end;

endmodule

// ===== src/utf8_byte_sanitizer_core.sv =====
// UTF-8 byte sanitizer.
// Input channel (i_valid / o_stall / i_in_beat): one string byte per beat, in_last
// on the final byte. Output channel (o_valid / i_stall / o_out_beat): sanitized
// bytes, well-formed sequences unchanged, each rejected byte replaced by '?'.
// A beat is taken at a clock edge where valid is high and stall is low.
// Throughput: one input beat per cycle while the queue has room, and one output
// beat per cycle while i_stall is low. A sequence's bytes are held until its last
// byte arrives, then leave as a burst of up to four beats, one per cycle unless
// stalled. A burst is written into the queue register and leaves from its head.
// The front decoder accepts a beat whenever the burst queue (QUEUE_DEPTH entries)
// has room; o_stall is the queue-full flag. A stalled receiver holds the output
// beat steady and backs the queue up until the front stalls too.
// Every string is flushed on in_last: a sequence still open becomes '?' bytes
// and out_last marks the final output beat.
// Reset (i_rst_n low, synchronous) closes any open sequence and empties the queue.
module utf8_byte_sanitizer_core import ubs_pkg::*; #(
    parameter int QUEUE_DEPTH = UBS_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_out_beat
);

    logic   w_push;
    t_burst w_burst;
    logic   w_pop;
    t_burst w_head;
    logic   w_head_valid;
    logic   w_full;

    ubs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_beat (i_in_beat),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_burst   (w_burst)
    );

    ubs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_burst      (w_burst),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_full)
    );

    ubs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_beat   (o_out_beat),
        .o_pop        (w_pop)
    );

    assign o_stall = w_full;

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("burst pushed into full queue");

    a_pop_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (o_valid && !i_stall))
        else $error("queue popped without an output beat");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_out_beat.out_last) |-> w_pop)
        else $error("out_last before the end of a burst");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
